@@ rtl/fcle_pkg.sv @@
// Shared types and constants for the framed command link engine.
`default_nettype none
package fcle_pkg;

  localparam int FLUSH_LEN = 12;
  localparam int MAX_REPLY = 512;
  localparam int LEN_W     = $clog2(MAX_REPLY + 1);
  localparam int STEP_W    = $clog2(FLUSH_LEN + 7);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam int IDLE_W  = 18;
  localparam int QUIET_W = 17;
  localparam int PAGE_W  = 9;
  localparam int CFG_W   = 18;
  localparam int CFGI_W  = 2;
  localparam int RLEN_W  = 10;
  localparam int IDX_W   = 9;

  localparam logic [IDLE_W-1:0]  IDLE_TIMEOUT_RST = 18'd200000;
  localparam logic [QUIET_W-1:0] QUIET_WINDOW_RST = 17'd100000;
  localparam logic [PAGE_W-1:0]  PAGE_LIMIT_RST   = 9'd256;

  localparam logic [CFGI_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_QUIET_WINDOW = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_PAGE_LIMIT   = 2'd2;

  localparam logic [1:0] ACT_ISSUE   = 2'd0;
  localparam logic [1:0] ACT_RX      = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;
  localparam logic [1:0] ACT_PAYLOAD = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_OVERRUN  = 3'd3;
  localparam logic [2:0] ST_PAGE     = 3'd4;

  localparam logic [7:0]  FLUSH_BYTE = 8'h5A;
  localparam logic [7:0]  HDR0       = 8'hCD;
  localparam logic [7:0]  HDR1       = 8'hD4;
  localparam logic [7:0]  HDR2       = 8'hF9;
  localparam logic [15:0] HDR_SUM    = 16'h029A;

  typedef enum logic [1:0] {
    K_SINGLE,
    K_FRAME,
    K_OVERRUN
  } desc_kind_t;

  // one queued job for the back end
  typedef struct packed {
    desc_kind_t       kind;
    logic             tx_valid;
    logic             rx_valid;
    logic [7:0]       data;
    logic [IDX_W-1:0] rx_index;
    logic             done;
    logic [2:0]       status;
    logic [7:0]       cmd;
    logic             with_page;
    logic [7:0]       page;
    logic [15:0]      chk;
    logic             end_done;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/fcle_in_if.sv @@
// Input channel: actions with command and data fields.
`default_nettype none
interface fcle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] command_code;
  logic       with_page;
  logic [7:0] page_num;
  logic [9:0] reply_length;
  logic [7:0] data_byte;

  modport source (output valid, action, command_code, with_page, page_num,
                  reply_length, data_byte, input ready);
  modport sink (input valid, action, command_code, with_page, page_num,
                reply_length, data_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/fcle_out_if.sv @@
// Result channel: tx byte, rx byte with index, completion status.
`default_nettype none
interface fcle_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic [8:0] rx_index;
  logic       done_res;
  logic [2:0] status;
  logic       last;

  modport source (output valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_index,
                  done_res, status, last, input ready);
  modport sink (input valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_index,
                done_res, status, last, output ready);
endinterface
`default_nettype wire

@@ rtl/fcle_cfg_if.sv @@
// Configuration write channel: register index and data.
`default_nettype none
interface fcle_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [17:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/fcle_queue.sv @@
// Small job queue between the front and back ends.
`default_nettype none
module fcle_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fcle_pkg::desc_t push_data,
  input  logic            pop,
  output fcle_pkg::desc_t head,
  output fcle_pkg::q_stat_t stat
);
  import fcle_pkg::*;

  desc_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fcle_front.sv @@
// Front end: takes words, runs the link state and queues output jobs.
`default_nettype none
module fcle_front (
  input  logic              clk,
  input  logic              rst,
  fcle_in_if.sink           req,
  fcle_cfg_if.sink          cfg,
  input  fcle_pkg::q_stat_t q_stat,
  output logic              push,
  output fcle_pkg::desc_t   push_data
);
  import fcle_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RECV,
    PH_QUIET
  } phase_t;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   byte_count, byte_count_next;
  logic [LEN_W-1:0]   expected_length, expected_length_next;
  logic [15:0]        running_sum, running_sum_next;
  logic [15:0]        received_check, received_check_next;
  logic [IDLE_W-1:0]  idle_count, idle_count_next;
  logic [QUIET_W-1:0] quiet_count, quiet_count_next;

  logic [IDLE_W-1:0]  idle_timeout;
  logic [QUIET_W-1:0] quiet_window;
  logic [PAGE_W-1:0]  page_limit;

  logic             accept;
  logic [LEN_W-1:0] rlen_sat;
  logic [LEN_W:0]   count_p2;
  logic [LEN_W:0]   count_p1;
  logic             busy;
  logic             has_check;

  assign req.ready = !q_stat.full;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign busy      = (phase == PH_RECV) || (phase == PH_QUIET);
  assign has_check = (expected_length >= LEN_W'(2));
  assign count_p2  = {1'b0, byte_count} + (LEN_W+1)'(2);
  assign count_p1  = {1'b0, byte_count} + (LEN_W+1)'(1);

  always_comb begin
    if (32'(req.reply_length) > MAX_REPLY) begin
      rlen_sat = LEN_W'(MAX_REPLY);
    end else begin
      rlen_sat = LEN_W'(req.reply_length);
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    received_check_next  = received_check;
    idle_count_next      = idle_count;
    quiet_count_next     = quiet_count;
    push                 = 1'b0;
    push_data            = '0;
    push_data.kind       = K_SINGLE;
    if (accept) begin
      case (req.action)
        ACT_ISSUE: begin
          if (!busy) begin
            push = 1'b1;
            if (req.with_page && ({1'b0, req.page_num} >= page_limit)) begin
              push_data.done   = 1'b1;
              push_data.status = ST_PAGE;
            end else begin
              push_data.kind      = K_FRAME;
              push_data.cmd       = req.command_code;
              push_data.with_page = req.with_page;
              push_data.page      = req.page_num;
              push_data.chk       = HDR_SUM + {8'h00, req.command_code}
                                  + (req.with_page ? {8'h00, req.page_num} : 16'h0000);
              push_data.end_done  = (rlen_sat == '0);
              if (rlen_sat != '0) begin
                phase_next           = PH_RECV;
                expected_length_next = rlen_sat;
                byte_count_next      = '0;
                running_sum_next     = '0;
                received_check_next  = '0;
                idle_count_next      = idle_timeout;
                quiet_count_next     = '0;
              end
            end
          end
        end
        ACT_RX: begin
          case (phase)
            PH_RECV: begin
              push               = 1'b1;
              push_data.rx_valid = 1'b1;
              push_data.data     = req.data_byte;
              push_data.rx_index = IDX_W'(byte_count);
              if (has_check && (count_p2 < {1'b0, expected_length})) begin
                running_sum_next = running_sum + {8'h00, req.data_byte};
              end else begin
                received_check_next = {received_check[7:0], req.data_byte};
              end
              idle_count_next = idle_timeout;
              byte_count_next = LEN_W'(count_p1);
              if (count_p1 >= {1'b0, expected_length}) begin
                phase_next       = PH_QUIET;
                quiet_count_next = quiet_window;
              end
            end
            PH_QUIET: begin
              push           = 1'b1;
              push_data.kind = K_OVERRUN;
              phase_next     = PH_IDLE;
            end
            default: ;
          endcase
        end
        ACT_TICK: begin
          case (phase)
            PH_RECV: begin
              if (idle_count <= IDLE_W'(1)) begin
                idle_count_next  = '0;
                push             = 1'b1;
                push_data.done   = 1'b1;
                push_data.status = ST_TIMEOUT;
                phase_next       = PH_IDLE;
              end else begin
                idle_count_next = idle_count - IDLE_W'(1);
              end
            end
            PH_QUIET: begin
              if (quiet_count <= QUIET_W'(1)) begin
                quiet_count_next = '0;
                push             = 1'b1;
                push_data.done   = 1'b1;
                push_data.status = (has_check && (running_sum != received_check))
                                 ? ST_CHECKSUM : ST_OK;
                phase_next       = PH_IDLE;
              end else begin
                quiet_count_next = quiet_count - QUIET_W'(1);
              end
            end
            default: ;
          endcase
        end
        ACT_PAYLOAD: begin
          push               = 1'b1;
          push_data.tx_valid = 1'b1;
          push_data.data     = req.data_byte;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      expected_length <= '0;
      running_sum     <= '0;
      received_check  <= '0;
      idle_count      <= '0;
      quiet_count     <= '0;
      idle_timeout    <= IDLE_TIMEOUT_RST;
      quiet_window    <= QUIET_WINDOW_RST;
      page_limit      <= PAGE_LIMIT_RST;
    end else begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      expected_length <= expected_length_next;
      running_sum     <= running_sum_next;
      received_check  <= received_check_next;
      idle_count      <= idle_count_next;
      quiet_count     <= quiet_count_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_IDLE_TIMEOUT: idle_timeout <= IDLE_W'(cfg.data);
          CFG_QUIET_WINDOW: quiet_window <= QUIET_W'(cfg.data);
          CFG_PAGE_LIMIT:   page_limit   <= PAGE_W'(cfg.data);
          default: ;
        endcase
      end
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_quiet_count_full: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_QUIET) |-> (byte_count == expected_length))
    else $error("quiet window entered before reply complete");

  a_recv_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RECV) |-> (byte_count < expected_length))
    else $error("reply count ran past expected length");

endmodule
`default_nettype wire

@@ rtl/fcle_back.sv @@
// Back end: expands queued jobs into result words through an output register.
`default_nettype none
module fcle_back (
  input  logic              clk,
  input  logic              rst,
  input  fcle_pkg::desc_t   head,
  input  fcle_pkg::q_stat_t q_stat,
  output logic              pop,
  fcle_out_if.source        rsp
);
  import fcle_pkg::*;

  localparam logic [2:0] POS_H0  = 3'd0;
  localparam logic [2:0] POS_H1  = 3'd1;
  localparam logic [2:0] POS_H2  = 3'd2;
  localparam logic [2:0] POS_CMD = 3'd3;
  localparam logic [2:0] POS_PG  = 3'd4;
  localparam logic [2:0] POS_HI  = 3'd5;
  localparam logic [2:0] POS_LO  = 3'd6;

  desc_t             cur;
  logic              cur_valid;
  logic [STEP_W-1:0] step;

  logic              load;
  logic              item_last;
  logic              item_txv;
  logic [7:0]        item_txb;
  logic              item_done;
  logic [2:0]        item_st;
  logic [2:0]        off;
  logic [2:0]        pos;

  assign load = cur_valid && (!rsp.valid || rsp.ready);
  assign pop  = !q_stat.empty && (!cur_valid || (load && item_last));
  assign off  = 3'(step - STEP_W'(FLUSH_LEN));
  assign pos  = (!cur.with_page && (off >= POS_PG)) ? (off + 3'd1) : off;

  always_comb begin
    item_last = 1'b0;
    item_txv  = 1'b0;
    item_txb  = '0;
    item_done = 1'b0;
    item_st   = ST_OK;
    case (cur.kind)
      K_SINGLE: begin
        item_last = 1'b1;
        item_txv  = cur.tx_valid;
        item_txb  = cur.tx_valid ? cur.data : 8'h00;
        item_done = cur.done;
        item_st   = cur.status;
      end
      K_OVERRUN: begin
        item_txv = 1'b1;
        item_txb = FLUSH_BYTE;
        if (step == STEP_W'(FLUSH_LEN - 1)) begin
          item_last = 1'b1;
          item_done = 1'b1;
          item_st   = ST_OVERRUN;
        end
      end
      K_FRAME: begin
        item_txv = 1'b1;
        if (step < STEP_W'(FLUSH_LEN)) begin
          item_txb = FLUSH_BYTE;
        end else begin
          case (pos)
            POS_H0:  item_txb = HDR0;
            POS_H1:  item_txb = HDR1;
            POS_H2:  item_txb = HDR2;
            POS_CMD: item_txb = cur.cmd;
            POS_PG:  item_txb = cur.page;
            POS_HI:  item_txb = cur.chk[15:8];
            POS_LO: begin
              item_txb  = cur.chk[7:0];
              item_last = 1'b1;
              item_done = cur.end_done;
            end
            default: item_txb = 8'h00;
          endcase
        end
      end
      default: item_last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (load) begin
        step <= step + STEP_W'(1);
        if (item_last) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (load) begin
      rsp.tx_valid <= item_txv;
      rsp.tx_byte  <= item_txb;
      rsp.rx_valid <= (cur.kind == K_SINGLE) && cur.rx_valid;
      rsp.rx_byte  <= ((cur.kind == K_SINGLE) && cur.rx_valid) ? cur.data : 8'h00;
      rsp.rx_index <= ((cur.kind == K_SINGLE) && cur.rx_valid) ? cur.rx_index : '0;
      rsp.done_res <= item_done;
      rsp.status   <= item_st;
      rsp.last     <= item_last;
    end
  end

  a_frame_step_range: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && (cur.kind == K_FRAME)) |-> (step <= STEP_W'(FLUSH_LEN + 6)))
    else $error("frame step past checksum low byte");

  a_single_one_step: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && (cur.kind == K_SINGLE)) |-> (step == '0))
    else $error("single job held past its word");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable({rsp.tx_byte, rsp.rx_byte, rsp.status, rsp.last})))
    else $error("result word changed while stalled");

endmodule
`default_nettype wire

@@ rtl/framed_command_link_engine.sv @@
// Top level of the framed command link engine.
//
//  channel  dir  handshake     carries
//  req      in   valid/ready   action, command_code, with_page, page_num,
//                              reply_length, data_byte
//  rsp      out  valid/ready   tx_valid/tx_byte, rx_valid/rx_byte/rx_index,
//                              done_res/status, last
//  cfg      in   valid/ready   index, data (idle_timeout, quiet_window, page_limit)
//
// The front end takes one req word per cycle while the 4-entry job queue has room.
// The back end sends one rsp word per cycle while rsp is ready; a command expands to up to 19 words.
// rsp is driven from an output register, so rsp stalls do not stop req until
// the queue fills. cfg is always ready.
// rst is synchronous and returns the link to idle with default register values.
`default_nettype none
module framed_command_link_engine (
  input  logic       clk,
  input  logic       rst,
  fcle_in_if.sink    req,
  fcle_out_if.source rsp,
  fcle_cfg_if.sink   cfg
);
  import fcle_pkg::*;

  logic    push;
  logic    pop;
  desc_t   push_data;
  desc_t   head;
  q_stat_t q_stat;

  fcle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  fcle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  fcle_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the framed command link engine.
`timescale 1ns / 100ps
module testbench;
  import fcle_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 60;
  localparam int STALL_CYCLES  = 400;
  localparam int PHASE_ITEMS   = 45;

  typedef enum logic [1:0] {
    LNK_IDLE,
    LNK_RECV,
    LNK_QUIET
  } link_phase_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        command_code;
    logic              with_page;
    logic [7:0]        page_num;
    logic [RLEN_W-1:0] reply_length;
    logic [7:0]        data_byte;
  } link_req_t;

  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             rx_valid;
    logic [7:0]       rx_byte;
    logic [IDX_W-1:0] rx_index;
    logic             done_res;
    logic [2:0]       status;
    logic             last;
  } link_word_t;

  typedef struct {
    bit                is_cfg;
    logic [CFGI_W-1:0] reg_index;
    logic [CFG_W-1:0]  reg_value;
    link_req_t         req;
    bit                typed;
    link_word_t        want;
  } stim_row_t;

  logic clk;
  logic rst;

  fcle_in_if  req_if();
  fcle_out_if rsp_if();
  fcle_cfg_if cfg_if();

  framed_command_link_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // link model state
  logic [IDLE_W-1:0]  lk_idle_timeout;
  logic [QUIET_W-1:0] lk_quiet_window;
  logic [PAGE_W-1:0]  lk_page_limit;
  link_phase_t        lk_phase;
  logic [9:0]         lk_byte_count;
  logic [9:0]         lk_exp_len;
  logic [15:0]        lk_run_sum;
  logic [15:0]        lk_rcv_check;
  logic [IDLE_W-1:0]  lk_idle_count;
  logic [QUIET_W-1:0] lk_quiet_count;

  link_word_t expected_words[$];
  link_word_t step_words[$];
  stim_row_t  stim_rows[$];

  int mismatches = 0;
  int cycle_count = 0;
  int req_idle_pct = 15;
  int rsp_idle_pct = 15;
  int big_replies_left = 0;
  bit stall_request = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d words outstanding", $time,
               expected_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic link_word_t mk_word(logic txv, logic [7:0] txb, logic rxv,
                                         logic [7:0] rxb, logic [IDX_W-1:0] rxi,
                                         logic done, logic [2:0] st);
    link_word_t w;
    w.tx_valid = txv;
    w.tx_byte  = txb;
    w.rx_valid = rxv;
    w.rx_byte  = rxb;
    w.rx_index = rxi;
    w.done_res = done;
    w.status   = st;
    w.last     = 1'b0;
    return w;
  endfunction

  function automatic link_word_t done_word(logic [2:0] st);
    return mk_word(1'b0, 8'h00, 1'b0, 8'h00, '0, 1'b1, st);
  endfunction

  function automatic link_req_t mk_req(logic [1:0] act, logic [7:0] cmd, logic wp,
                                       logic [7:0] pg, logic [RLEN_W-1:0] rlen,
                                       logic [7:0] data);
    link_req_t r;
    r.action       = act;
    r.command_code = cmd;
    r.with_page    = wp;
    r.page_num     = pg;
    r.reply_length = rlen;
    r.data_byte    = data;
    return r;
  endfunction

  function automatic void reset_link_model();
    lk_idle_timeout = IDLE_TIMEOUT_RST;
    lk_quiet_window = QUIET_WINDOW_RST;
    lk_page_limit   = PAGE_LIMIT_RST;
    lk_phase        = LNK_IDLE;
    lk_byte_count   = '0;
    lk_exp_len      = '0;
    lk_run_sum      = '0;
    lk_rcv_check    = '0;
    lk_idle_count   = '0;
    lk_quiet_count  = '0;
  endfunction

  // Words the link produces for one request, left in step_words.
  function automatic void predict_link_words(link_req_t r);
    logic [15:0] sum;
    logic [9:0]  rlen;
    logic [2:0]  st;
    bit          busy;
    step_words.delete();
    busy = (lk_phase == LNK_RECV || lk_phase == LNK_QUIET);
    case (r.action)
      ACT_ISSUE: begin
        if (!busy) begin
          if (r.with_page && {1'b0, r.page_num} >= lk_page_limit) begin
            step_words.push_back(done_word(ST_PAGE));
          end else begin
            repeat (FLUSH_LEN) step_words.push_back(mk_word(1'b1, FLUSH_BYTE, 1'b0,
                                                            8'h00, '0, 1'b0, ST_OK));
            sum = HDR_SUM + 16'(r.command_code);
            step_words.push_back(mk_word(1'b1, HDR0, 1'b0, 8'h00, '0, 1'b0, ST_OK));
            step_words.push_back(mk_word(1'b1, HDR1, 1'b0, 8'h00, '0, 1'b0, ST_OK));
            step_words.push_back(mk_word(1'b1, HDR2, 1'b0, 8'h00, '0, 1'b0, ST_OK));
            step_words.push_back(mk_word(1'b1, r.command_code, 1'b0, 8'h00, '0, 1'b0,
                                         ST_OK));
            if (r.with_page) begin
              sum = sum + 16'(r.page_num);
              step_words.push_back(mk_word(1'b1, r.page_num, 1'b0, 8'h00, '0, 1'b0,
                                           ST_OK));
            end
            rlen = (r.reply_length > MAX_REPLY) ? 10'(MAX_REPLY) : r.reply_length;
            step_words.push_back(mk_word(1'b1, sum[15:8], 1'b0, 8'h00, '0, 1'b0, ST_OK));
            step_words.push_back(mk_word(1'b1, sum[7:0], 1'b0, 8'h00, '0, rlen == 0,
                                         ST_OK));
            if (rlen != 0) begin
              lk_phase       = LNK_RECV;
              lk_exp_len     = rlen;
              lk_byte_count  = '0;
              lk_run_sum     = '0;
              lk_rcv_check   = '0;
              lk_idle_count  = lk_idle_timeout;
              lk_quiet_count = '0;
            end
          end
        end
      end
      ACT_RX: begin
        if (lk_phase == LNK_RECV) begin
          step_words.push_back(mk_word(1'b0, 8'h00, 1'b1, r.data_byte,
                                       lk_byte_count[IDX_W-1:0], 1'b0, ST_OK));
          // the last two bytes of the reply are its checksum
          if (lk_exp_len >= 2 && int'(lk_byte_count) + 2 < int'(lk_exp_len))
            lk_run_sum = lk_run_sum + 16'(r.data_byte);
          else
            lk_rcv_check = {lk_rcv_check[7:0], r.data_byte};
          lk_idle_count = lk_idle_timeout;
          lk_byte_count = lk_byte_count + 10'd1;
          if (lk_byte_count >= lk_exp_len) begin
            lk_phase       = LNK_QUIET;
            lk_quiet_count = lk_quiet_window;
          end
        end else if (lk_phase == LNK_QUIET) begin
          repeat (FLUSH_LEN) step_words.push_back(mk_word(1'b1, FLUSH_BYTE, 1'b0, 8'h00,
                                                          '0, 1'b0, ST_OK));
          step_words[step_words.size() - 1].done_res = 1'b1;
          step_words[step_words.size() - 1].status   = ST_OVERRUN;
          lk_phase = LNK_IDLE;
        end
      end
      ACT_TICK: begin
        if (lk_phase == LNK_RECV) begin
          if (lk_idle_count <= 1) begin
            lk_idle_count = '0;
            step_words.push_back(done_word(ST_TIMEOUT));
            lk_phase = LNK_IDLE;
          end else begin
            lk_idle_count = lk_idle_count - IDLE_W'(1);
          end
        end else if (lk_phase == LNK_QUIET) begin
          if (lk_quiet_count <= 1) begin
            lk_quiet_count = '0;
            st = (lk_exp_len >= 2 && lk_run_sum != lk_rcv_check) ? ST_CHECKSUM : ST_OK;
            step_words.push_back(done_word(st));
            lk_phase = LNK_IDLE;
          end else begin
            lk_quiet_count = lk_quiet_count - QUIET_W'(1);
          end
        end
      end
      default: begin
        step_words.push_back(mk_word(1'b1, r.data_byte, 1'b0, 8'h00, '0, 1'b0, ST_OK));
      end
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic bit link_ignores(link_req_t r);
    if (r.action == ACT_ISSUE) return lk_phase != LNK_IDLE;
    if (r.action == ACT_RX || r.action == ACT_TICK) return lk_phase == LNK_IDLE;
    return 1'b0;
  endfunction

  // Mostly well-formed transactions, with noise mixed in.
  function automatic link_req_t gen_link_req();
    link_req_t r;
    int roll;
    r.action       = ACT_PAYLOAD;
    r.command_code = 8'($urandom);
    r.with_page    = 1'($urandom_range(0, 1));
    r.page_num     = 8'($urandom);
    r.reply_length = 10'($urandom_range(0, 1023));
    r.data_byte    = 8'($urandom);
    roll = $urandom_range(0, 99);
    case (lk_phase)
      LNK_RECV: begin
        if (roll < 65) begin
          r.action = ACT_RX;
          if (lk_exp_len >= 2 && int'(lk_byte_count) + 2 >= int'(lk_exp_len) &&
              $urandom_range(0, 99) < 75)
            r.data_byte = (int'(lk_byte_count) + 2 == int'(lk_exp_len)) ?
                          lk_run_sum[15:8] : lk_run_sum[7:0];
        end else if (roll < 80) begin
          r.action = ACT_TICK;
        end else if (roll < 93) begin
          r.action = ACT_PAYLOAD;
        end else begin
          r.action = ACT_ISSUE;
        end
      end
      LNK_QUIET: begin
        if (roll < 75) r.action = ACT_TICK;
        else if (roll < 88) r.action = ACT_RX;
        else r.action = ACT_PAYLOAD;
      end
      default: begin
        if (roll < 85) begin
          r.action = ACT_ISSUE;
          roll = $urandom_range(0, 99);
          if (roll < 10) begin
            r.reply_length = '0;
          end else if (roll >= 97 && big_replies_left > 0) begin
            big_replies_left--;
            r.reply_length = 10'($urandom_range(512, 1023));
          end else begin
            r.reply_length = 10'($urandom_range(1, 8));
          end
        end else begin
          r.action = 2'($urandom_range(1, 3));
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_req(link_req_t r, bit typed, link_word_t want);
    stim_row_t row;
    row.is_cfg    = 1'b0;
    row.reg_index = '0;
    row.reg_value = '0;
    row.req       = r;
    row.typed     = typed;
    row.want      = want;
    row.want.last = 1'b1;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] val);
    stim_row_t row;
    row.is_cfg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = val;
    row.req       = '0;
    row.typed     = 1'b0;
    row.want      = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic send_req(input link_req_t r, input bit typed, input link_word_t want);
    if ($urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.command_code <= r.command_code;
    req_if.with_page    <= r.with_page;
    req_if.page_num     <= r.page_num;
    req_if.reply_length <= r.reply_length;
    req_if.data_byte    <= r.data_byte;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_link_words(r);
    if (typed) expected_words.push_back(want);
    else foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  task automatic wait_results();
    req_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_results();
    // a tick or byte that makes no word may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_IDLE_TIMEOUT: lk_idle_timeout = val[IDLE_W-1:0];
      CFG_QUIET_WINDOW: lk_quiet_window = val[QUIET_W-1:0];
      CFG_PAGE_LIMIT:   lk_page_limit   = val[PAGE_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // bring the link back to idle with reply bytes; overrun ends the quiet window
  task automatic close_link();
    while (lk_phase != LNK_IDLE)
      send_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'($urandom)), 1'b0, '0);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side: check each accepted word, then pick next ready
  initial begin
    link_word_t want;
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_words.size() == 0) begin
          $display({"%0t: unexpected word: expected none, actual tx %0b/%02h",
                    " rx %0b/%02h/%0d done %0b/%0d"},
                   $time, rsp_if.tx_valid, rsp_if.tx_byte, rsp_if.rx_valid,
                   rsp_if.rx_byte, rsp_if.rx_index, rsp_if.done_res, rsp_if.status);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("tx_valid", 32'(want.tx_valid), 32'(rsp_if.tx_valid));
          check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_if.tx_byte));
          check_field("rx_valid", 32'(want.rx_valid), 32'(rsp_if.rx_valid));
          check_field("rx_byte", 32'(want.rx_byte), 32'(rsp_if.rx_byte));
          check_field("rx_index", 32'(want.rx_index), 32'(rsp_if.rx_index));
          check_field("done_res", 32'(want.done_res), 32'(rsp_if.done_res));
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("last", 32'(want.last), 32'(rsp_if.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_request) begin
        stall_request = 1'b0;
        stall_left = STALL_CYCLES;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
    end
  end

  initial begin
    link_req_t r;
    int counted;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_PAYLOAD;
    req_if.command_code <= '0;
    req_if.with_page    <= 1'b0;
    req_if.page_num     <= '0;
    req_if.reply_length <= '0;
    req_if.data_byte    <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_IDLE_TIMEOUT;
    cfg_if.data         <= '0;
    rst                 <= 1'b1;
    reset_link_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset registers first, then tight windows
    add_req(mk_req(ACT_PAYLOAD, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b1,
            mk_word(1'b1, 8'h00, 1'b0, 8'h00, '0, 1'b0, ST_OK));
    add_req(mk_req(ACT_PAYLOAD, 8'h00, 1'b0, 8'h00, '0, 8'hFF), 1'b1,
            mk_word(1'b1, 8'hFF, 1'b0, 8'h00, '0, 1'b0, ST_OK));
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h33), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_ISSUE, 8'h00, 1'b0, 8'h00, 10'd0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_ISSUE, 8'hFF, 1'b1, 8'hFF, 10'd0, 8'h00), 1'b0, '0);
    add_cfg(CFG_PAGE_LIMIT, 18'd1);
    add_req(mk_req(ACT_ISSUE, 8'h11, 1'b1, 8'h01, 10'd4, 8'h00), 1'b1, done_word(ST_PAGE));
    add_req(mk_req(ACT_ISSUE, 8'h5A, 1'b1, 8'h00, 10'd0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_ISSUE, 8'h22, 1'b0, 8'hFF, 10'd0, 8'h00), 1'b0, '0);
    add_cfg(CFG_IDLE_TIMEOUT, 18'd2);
    add_cfg(CFG_QUIET_WINDOW, 18'd2);
    add_req(mk_req(ACT_ISSUE, 8'h12, 1'b0, 8'h00, 10'd3, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_ISSUE, 8'h99, 1'b0, 8'h00, 10'd3, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h10), 1'b0, '0);
    add_req(mk_req(ACT_PAYLOAD, 8'h00, 1'b0, 8'h00, '0, 8'hA5), 1'b1,
            mk_word(1'b1, 8'hA5, 1'b0, 8'h00, '0, 1'b0, ST_OK));
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h10), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b1, done_word(ST_OK));
    // one-byte reply has no checksum
    add_req(mk_req(ACT_ISSUE, 8'h34, 1'b0, 8'h00, 10'd1, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'hFF), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b1, done_word(ST_OK));
    add_req(mk_req(ACT_ISSUE, 8'h77, 1'b0, 8'h00, 10'd2, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'hAB), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b1, done_word(ST_TIMEOUT));
    add_req(mk_req(ACT_ISSUE, 8'h01, 1'b0, 8'h00, 10'd2, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h01), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_TICK, 8'h00, 1'b0, 8'h00, '0, 8'h00), 1'b1, done_word(ST_CHECKSUM));
    add_req(mk_req(ACT_ISSUE, 8'h56, 1'b0, 8'h00, 10'd1, 8'h00), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h42), 1'b0, '0);
    add_req(mk_req(ACT_RX, 8'h00, 1'b0, 8'h00, '0, 8'h43), 1'b0, '0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_reg(stim_rows[i].reg_index, stim_rows[i].reg_value);
      else send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      close_link();
      case (ph)
        0: begin
          write_reg(CFG_IDLE_TIMEOUT, 18'd3);
          write_reg(CFG_QUIET_WINDOW, 18'd3);
          write_reg(CFG_PAGE_LIMIT, 18'd256);
        end
        1: begin
          write_reg(CFG_IDLE_TIMEOUT, 18'd1);
          write_reg(CFG_QUIET_WINDOW, 18'd1);
          write_reg(CFG_PAGE_LIMIT, 18'd1);
        end
        2: begin
          write_reg(CFG_IDLE_TIMEOUT, 18'd262143);
          write_reg(CFG_QUIET_WINDOW, 18'd131071);
          write_reg(CFG_PAGE_LIMIT, 18'd256);
          big_replies_left = 1;
        end
        default: begin
          write_reg(CFG_IDLE_TIMEOUT, 18'($urandom_range(2, 12)));
          write_reg(CFG_QUIET_WINDOW, 18'($urandom_range(1, 8)));
          write_reg(CFG_PAGE_LIMIT, 18'($urandom_range(1, 256)));
        end
      endcase
      if (ph == 5) begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if (ph == 3 && counted == 10) stall_request = 1'b1;
        if (ph == 4 && counted == 25) wait_results();
        r = gen_link_req();
        if (!link_ignores(r)) counted++;
        send_req(r, 1'b0, '0);
      end
      req_idle_pct = 15;
      rsp_idle_pct = 15;
    end

    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
